// ===== hdl/lvq_pkg.sv =====
`default_nettype none
package lvq_pkg;

  localparam int MAX_PROTOTYPES_DEF = 16;
  localparam int MAX_FEATURES_DEF   = 16;
  localparam int MAX_CLASSES_DEF    = 4;

  localparam int CLS_W = 3;

  localparam logic [4:0]  FEATURES_RST = 5'd16;
  localparam logic [2:0]  CLASSES_RST  = 3'd2;
  localparam logic [3:0]  PPC_RST      = 4'd4;
  localparam logic [31:0] RATE_RST     = 32'd42949673;
  localparam logic [31:0] DECAY_RST    = 32'd4294963001;
  localparam logic [15:0] WINDOW_RST   = 16'd60398;
  localparam logic [14:0] RATE_0P4     = 15'd26214;

  localparam logic KIND_CLASS  = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_WRITE    = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_FEATURES  = 3'd0,
    CFG_CLASSES   = 3'd1,
    CFG_PPC       = 3'd2,
    CFG_INIT_RATE = 3'd3,
    CFG_DECAY     = 3'd4,
    CFG_WINDOW    = 3'd5
  } cfg_e;

  typedef enum logic [2:0] {
    UPD_NONE     = 3'd0,
    UPD_ATTR_REP = 3'd1,
    UPD_REP_ATTR = 3'd2,
    UPD_BOTH     = 3'd3,
    UPD_CLASS    = 3'd4
  } upd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_WALK,
    ST_WDRAIN,
    ST_WIN,
    ST_DECIDE,
    ST_UPD,
    ST_UDRAIN,
    ST_DECAY,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic elem_write;
    logic wr_weight;
    logic rd_weight;
    logic walk_issue;
    logic walk_first;
    logic walk_last;
    logic win;
    logic decide;
    logic upd_issue;
    logic upd_pass;
    logic decay;
    logic load_class;
    logic load_read;
  } cmd_t;

  typedef struct packed {
    logic train;
    logic upd_any;
    logic upd_two;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/lvq_ctrl.sv =====
`default_nettype none
module lvq_ctrl #(
  parameter int MAX_P = lvq_pkg::MAX_PROTOTYPES_DEF,
  parameter int MAX_F = lvq_pkg::MAX_FEATURES_DEF,
  parameter int PW    = (MAX_P > 1) ? $clog2(MAX_P) : 1,
  parameter int FW    = (MAX_F > 1) ? $clog2(MAX_F) : 1,
  parameter int PCW   = $clog2(MAX_P + 1),
  parameter int FCW   = $clog2(MAX_F + 1)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  lvq_pkg::op_e              in_op_i,
  input  wire                       in_last_i,
  input  lvq_pkg::sts_t             sts_i,
  input  wire  [FCW-1:0]            nf_i,
  input  wire  [PCW-1:0]            h_i,
  input  wire  [3:0]                ppc_i,
  output lvq_pkg::cmd_t             cmd_o,
  output logic [PW-1:0]             proto_o,
  output logic [FW-1:0]             feat_o,
  output logic [lvq_pkg::CLS_W-1:0] cls_o
);
  import lvq_pkg::*;

  state_e st_q, st_d;
  logic [PW-1:0]    i_q, i_d;
  logic [FCW-1:0]   j_q, j_d;
  logic [3:0]       k_q, k_d;
  logic [CLS_W-1:0] c_q, c_d;
  logic [1:0]       dr_q, dr_d;
  logic             pass_q, pass_d;
  logic             j_end, i_end;

  assign j_end   = (j_q + 1'b1) == nf_i;
  assign i_end   = (PCW'(i_q) + 1'b1) == h_i;
  assign proto_o = i_q;
  assign feat_o  = j_q[FW-1:0];
  assign cls_o   = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      c_q    <= '0;
      dr_q   <= '0;
      pass_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      i_q    <= i_d;
      j_q    <= j_d;
      k_q    <= k_d;
      c_q    <= c_d;
      dr_q   <= dr_d;
      pass_q <= pass_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    c_d        = c_q;
    dr_d       = dr_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_op_i) inside
            OP_WRITE: cmd_o.wr_weight = 1'b1;
            OP_READ: begin
              cmd_o.rd_weight = 1'b1;
              st_d = ST_RDOUT;
            end
            OP_CLASSIFY, OP_TRAIN: begin
              cmd_o.elem_write = 1'b1;
              if (in_last_i) begin
                st_d = ST_WALK;
                i_d  = '0;
                j_d  = '0;
                k_d  = '0;
                c_d  = '0;
              end
            end
          endcase
        end
      end
      ST_RDOUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_read = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.walk_issue = 1'b1;
        cmd_o.walk_first = (j_q == '0);
        cmd_o.walk_last  = j_end;
        if (j_end) begin
          j_d = '0;
          i_d = i_q + 1'b1;
          if ((k_q + 1'b1) == ppc_i) begin
            k_d = '0;
            c_d = c_q + 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
          if (i_end) begin
            st_d = ST_WDRAIN;
            dr_d = '0;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_WDRAIN: begin
        dr_d = dr_q + 1'b1;
        if (dr_q == 2'd2) st_d = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.win = 1'b1;
        st_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        j_d    = '0;
        pass_d = 1'b0;
        if (!sts_i.train) st_d = ST_RESULT;
        else if (sts_i.upd_any) st_d = ST_UPD;
        else st_d = ST_DECAY;
      end
      ST_UPD: begin
        cmd_o.upd_issue = 1'b1;
        cmd_o.upd_pass  = pass_q;
        if (j_end) begin
          j_d = '0;
          if (!pass_q && sts_i.upd_two) begin
            pass_d = 1'b1;
          end else begin
            st_d = ST_UDRAIN;
            dr_d = '0;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_UDRAIN: begin
        dr_d = dr_q + 1'b1;
        if (dr_q == 2'd1) st_d = ST_DECAY;
      end
      ST_DECAY: begin
        cmd_o.decay = 1'b1;
        st_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_class = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/lvq_datapath.sv =====
`default_nettype none
module lvq_datapath #(
  parameter int MAX_P = lvq_pkg::MAX_PROTOTYPES_DEF,
  parameter int MAX_F = lvq_pkg::MAX_FEATURES_DEF,
  parameter int MAX_C = lvq_pkg::MAX_CLASSES_DEF,
  parameter int PW    = (MAX_P > 1) ? $clog2(MAX_P) : 1,
  parameter int FW    = (MAX_F > 1) ? $clog2(MAX_F) : 1,
  parameter int PCW   = $clog2(MAX_P + 1),
  parameter int FCW   = $clog2(MAX_F + 1)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [2:0]                cfg_index_i,
  input  wire  [31:0]               cfg_data_i,
  input  lvq_pkg::op_e              in_op_i,
  input  wire  [15:0]               in_value_i,
  input  wire                       in_last_i,
  input  wire  [1:0]                in_true_class_i,
  input  wire  [3:0]                in_proto_i,
  input  wire  [3:0]                in_feat_i,
  input  lvq_pkg::cmd_t             cmd_i,
  input  wire  [PW-1:0]             proto_i,
  input  wire  [FW-1:0]             feat_i,
  input  wire  [lvq_pkg::CLS_W-1:0] cls_i,
  output lvq_pkg::sts_t             sts_o,
  output logic [FCW-1:0]            nf_o,
  output logic [PCW-1:0]            h_o,
  output logic [3:0]                ppc_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic                      out_kind_o,
  output logic [1:0]                out_class_o,
  output logic [3:0]                out_winner_o,
  output logic [3:0]                out_runner_o,
  output logic [2:0]                out_case_o,
  output logic [15:0]               out_weight_o
);
  import lvq_pkg::*;

  localparam int MAW    = PW + FW;
  localparam int MDEPTH = MAX_P * (1 << FW);
  localparam int DW     = 32 + FW;

  // configuration and rate
  logic [4:0]  feat_q;
  logic [2:0]  ncls_q;
  logic [3:0]  ppc_q;
  logic [31:0] decay_q;
  logic [15:0] window_q;
  logic [31:0] rate_q;
  logic [63:0] decay_prod;

  assign decay_prod = 64'(rate_q) * 64'(decay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_q   <= FEATURES_RST;
      ncls_q   <= CLASSES_RST;
      ppc_q    <= PPC_RST;
      decay_q  <= DECAY_RST;
      window_q <= WINDOW_RST;
      rate_q   <= RATE_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FEATURES:  feat_q   <= cfg_data_i[4:0];
          CFG_CLASSES:   ncls_q   <= cfg_data_i[2:0];
          CFG_PPC:       ppc_q    <= cfg_data_i[3:0];
          CFG_INIT_RATE: rate_q   <= cfg_data_i;
          CFG_DECAY:     decay_q  <= cfg_data_i;
          CFG_WINDOW:    window_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.decay) rate_q <= decay_prod[63:32];
    end
  end

  int nf_int, c_int, h_int;
  always_comb begin
    nf_int = int'(feat_q);
    if (nf_int == 0) nf_int = 1;
    if (nf_int > MAX_F) nf_int = MAX_F;
    c_int = int'(ncls_q);
    if (c_int < 2) c_int = 2;
    if (c_int > MAX_C) c_int = MAX_C;
    ppc_o = (ppc_q == 4'd0) ? 4'd1 : ppc_q;
    h_int = c_int * int'(ppc_o);
    if (h_int > MAX_P) h_int = MAX_P;
    nf_o = FCW'(nf_int);
    h_o  = PCW'(h_int);
  end

  // sample buffer
  logic [FCW-1:0]      cnt_q;
  logic                train_q;
  logic [1:0]          tcls_q;
  logic signed [15:0]  sbuf_mem [MAX_F];
  logic signed [15:0]  x_rd_q;
  logic                start;

  assign start = cmd_i.elem_write && in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      train_q <= 1'b0;
      tcls_q  <= '0;
    end else if (cmd_i.elem_write) begin
      if (in_last_i) begin
        cnt_q   <= '0;
        train_q <= (in_op_i == OP_TRAIN);
        tcls_q  <= in_true_class_i;
      end else if (cnt_q < nf_o) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_write && cnt_q < nf_o) sbuf_mem[cnt_q[FW-1:0]] <= in_value_i;
    if (cmd_i.walk_issue || cmd_i.upd_issue) x_rd_q <= sbuf_mem[feat_i];
  end

  // weight memory
  logic [31:0]        pi_ext, fi_ext;
  logic               addr_ok;
  logic [MAW-1:0]     io_addr;
  logic [PW-1:0]      pa_q, pb_q, upd_proto;
  logic               wm_we, wm_re;
  logic [MAW-1:0]     wm_waddr, wm_raddr;
  logic signed [15:0] wm_wdata;
  logic signed [15:0] wmem [MDEPTH];
  logic signed [15:0] w_rd_q;
  logic               rd_ok_q;
  logic               u2_v_q;
  logic [MAW-1:0]     u2_addr_q;
  logic signed [15:0] upd_new;

  assign pi_ext    = 32'(in_proto_i);
  assign fi_ext    = 32'(in_feat_i);
  assign addr_ok   = (pi_ext < MAX_P) && (fi_ext < MAX_F);
  assign io_addr   = {pi_ext[PW-1:0], fi_ext[FW-1:0]};
  assign upd_proto = cmd_i.upd_pass ? pb_q : pa_q;

  always_comb begin
    wm_re    = cmd_i.rd_weight || cmd_i.walk_issue || cmd_i.upd_issue;
    wm_raddr = io_addr;
    if (cmd_i.walk_issue) wm_raddr = {proto_i, feat_i};
    else if (cmd_i.upd_issue) wm_raddr = {upd_proto, feat_i};
    wm_we    = (cmd_i.wr_weight && addr_ok) || u2_v_q;
    wm_waddr = u2_v_q ? u2_addr_q : io_addr;
    wm_wdata = u2_v_q ? upd_new : in_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) wmem[wm_waddr] <= wm_wdata;
    if (wm_re) w_rd_q <= wmem[wm_raddr];
    if (cmd_i.rd_weight) rd_ok_q <= addr_ok;
  end

  // shared first stage: difference, square, scaled magnitude
  logic signed [16:0] dif;
  logic signed [33:0] dif_w;
  logic [33:0]        sq_full;
  logic [16:0]        mag17;
  logic [31:0]        rate_sel;
  logic [47:0]        mag_prod;
  logic               use_r3_q;
  logic [31:0]        r3_q;

  assign dif      = {x_rd_q[15], x_rd_q} - {w_rd_q[15], w_rd_q};
  assign dif_w    = 34'(dif);
  assign sq_full  = dif_w * dif_w;
  assign mag17    = dif[16] ? 17'(-dif) : 17'(dif);
  assign rate_sel = use_r3_q ? r3_q : rate_q;
  assign mag_prod = 48'(mag17[15:0]) * 48'(rate_sel);

  // distance walk
  logic                s1_v_q, s1_first_q, s1_last_q;
  logic [PW-1:0]       s1_idx_q;
  logic [CLS_W-1:0]    s1_cls_q;
  logic                s2_v_q, s2_first_q, s2_last_q;
  logic [PW-1:0]       s2_idx_q;
  logic [CLS_W-1:0]    s2_cls_q;
  logic [31:0]         sq_q;
  logic                s3_v_q;
  logic [PW-1:0]       s3_idx_q;
  logic [CLS_W-1:0]    s3_cls_q;
  logic [DW-1:0]       acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.walk_issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.walk_first;
    s1_last_q  <= cmd_i.walk_last;
    s1_idx_q   <= proto_i;
    s1_cls_q   <= cls_i;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_idx_q   <= s1_idx_q;
    s2_cls_q   <= s1_cls_q;
    sq_q       <= sq_full[31:0];
    s3_idx_q   <= s2_idx_q;
    s3_cls_q   <= s2_cls_q;
    if (s2_v_q) acc_q <= (s2_first_q ? '0 : acc_q) + DW'(sq_q);
  end

  // nearest, second nearest and nearest of the true class
  logic [DW-1:0]    d1_q, d2_q, dc_q;
  logic [PW-1:0]    i1_q, i2_q, ic_q;
  logic [CLS_W-1:0] c1_q, c2_q;
  logic             h1_q, h2_q, hc_q;
  logic             in_true;

  assign in_true = (s3_cls_q == CLS_W'(tcls_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= 1'b0;
      h2_q <= 1'b0;
      hc_q <= 1'b0;
    end else if (start) begin
      h1_q <= 1'b0;
      h2_q <= 1'b0;
      hc_q <= 1'b0;
    end else if (s3_v_q) begin
      if (!h1_q || acc_q < d1_q) begin
        h1_q <= 1'b1;
        h2_q <= h1_q;
      end else if (!h2_q || acc_q < d2_q) begin
        h2_q <= 1'b1;
      end
      if (in_true && (!hc_q || acc_q < dc_q)) hc_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      if (!h1_q || acc_q < d1_q) begin
        d2_q <= d1_q;
        i2_q <= i1_q;
        c2_q <= c1_q;
        d1_q <= acc_q;
        i1_q <= s3_idx_q;
        c1_q <= s3_cls_q;
      end else if (!h2_q || acc_q < d2_q) begin
        d2_q <= acc_q;
        i2_q <= s3_idx_q;
        c2_q <= s3_cls_q;
      end
      if (in_true && (!hc_q || acc_q < dc_q)) begin
        dc_q <= acc_q;
        ic_q <= s3_idx_q;
      end
    end
  end

  // window test and update case
  logic [DW+15:0] winp_q;
  logic [47:0]    r3_sum;
  logic           differ, t1, t2, inwin;
  upd_e           ucase, case_q;
  logic           da_q, db_q;

  assign r3_sum = 48'(rate_q) * 48'(RATE_0P4) + 48'h8000;
  assign differ = (c1_q != c2_q);
  assign t1     = (c1_q == CLS_W'(tcls_q));
  assign t2     = (c2_q == CLS_W'(tcls_q));
  assign inwin  = {d1_q, 16'h0000} > winp_q;

  always_comb begin
    if (!train_q) ucase = UPD_NONE;
    else if (differ && t1 && inwin) ucase = UPD_ATTR_REP;
    else if (differ && t2 && inwin) ucase = UPD_REP_ATTR;
    else if (!differ && t1 && inwin) ucase = UPD_BOTH;
    else if (!t1 && !t2 && hc_q) ucase = UPD_CLASS;
    else ucase = UPD_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      winp_q <= (DW+16)'(window_q) * (DW+16)'(d2_q);
      r3_q   <= r3_sum[47:16];
    end
    if (cmd_i.decide) begin
      case_q   <= ucase;
      use_r3_q <= (ucase == UPD_BOTH);
      pa_q     <= (ucase == UPD_CLASS) ? ic_q : i1_q;
      pb_q     <= i2_q;
      da_q     <= (ucase != UPD_REP_ATTR);
      db_q     <= (ucase != UPD_ATTR_REP);
    end
  end

  assign sts_o.train    = train_q;
  assign sts_o.upd_any  = (ucase != UPD_NONE);
  assign sts_o.upd_two  = (case_q == UPD_ATTR_REP) || (case_q == UPD_REP_ATTR) ||
                          (case_q == UPD_BOTH);
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  // weight update pipeline
  logic               u1_v_q, u1_dir_q;
  logic [MAW-1:0]     u1_addr_q;
  logic [47:0]        u2_prod_q;
  logic               u2_neg_q, u2_dir_q;
  logic signed [15:0] u2_w_q;
  logic [48:0]        rnd;
  logic signed [17:0] w18, d18, sum18;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_v_q <= 1'b0;
      u2_v_q <= 1'b0;
    end else begin
      u1_v_q <= cmd_i.upd_issue;
      u2_v_q <= u1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_dir_q  <= cmd_i.upd_pass ? db_q : da_q;
    u1_addr_q <= {upd_proto, feat_i};
    u2_prod_q <= mag_prod;
    u2_neg_q  <= dif[16];
    u2_dir_q  <= u1_dir_q;
    u2_w_q    <= w_rd_q;
    u2_addr_q <= u1_addr_q;
  end

  always_comb begin
    rnd   = 49'(u2_prod_q) + 49'h0_8000_0000;
    w18   = 18'(u2_w_q);
    d18   = $signed({1'b0, rnd[48:32]});
    sum18 = (u2_neg_q ^ !u2_dir_q) ? (w18 - d18) : (w18 + d18);
    if (sum18 > 18'sd32767) upd_new = 16'sh7FFF;
    else if (sum18 < -18'sd32768) upd_new = 16'sh8000;
    else upd_new = sum18[15:0];
  end

  // result register
  logic [31:0] i1_ext, i2_ext;
  assign i1_ext = 32'(i1_q);
  assign i2_ext = 32'(i2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_class || cmd_i.load_read) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_class) begin
      out_kind_o   <= KIND_CLASS;
      out_class_o  <= c1_q[1:0];
      out_winner_o <= i1_ext[3:0];
      out_runner_o <= train_q ? i2_ext[3:0] : 4'd0;
      out_case_o   <= case_q;
      out_weight_o <= '0;
    end else if (cmd_i.load_read) begin
      out_kind_o   <= KIND_WEIGHT;
      out_class_o  <= '0;
      out_winner_o <= '0;
      out_runner_o <= '0;
      out_case_o   <= UPD_NONE;
      out_weight_o <= rd_ok_q ? w_rd_q : 16'sh0000;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lvq_classify_and_train_core.sv =====
// weight write and non-final sample element: accepted back to back, no result
// weight read: word registered from memory, result loaded once the output is free
// final element: the distance walk (one weight memory read a cycle), the decision, and in
//   train mode the update of one or two prototypes and the rate decay (the decay also
//   when no update applies); H prototypes of N elements are walked
// reset: asynchronous active low; clears control, registers to defaults, rate to its default
//   start value; weight and sample memories are not cleared
`default_nettype none
module lvq_classify_and_train_core #(
  parameter int MAX_PROTOTYPES = lvq_pkg::MAX_PROTOTYPES_DEF,
  parameter int MAX_FEATURES   = lvq_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES    = lvq_pkg::MAX_CLASSES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // feature_value, true_class, prototype_index, feature_index, zero pad
  input  wire  [31:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  // operation
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // predicted_class, winner_index, runner_up_index, update_case, weight_value, zero pad
  output logic [31:0] m_axis_tdata,
  // result_kind
  output logic [0:0]  m_axis_tuser,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import lvq_pkg::*;

  localparam int PW  = (MAX_PROTOTYPES > 1) ? $clog2(MAX_PROTOTYPES) : 1;
  localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PCW = $clog2(MAX_PROTOTYPES + 1);
  localparam int FCW = $clog2(MAX_FEATURES + 1);

  op_e              in_op;
  cmd_t             cmd;
  sts_t             sts;
  logic [PW-1:0]    proto;
  logic [FW-1:0]    feat;
  logic [CLS_W-1:0] cls;
  logic [FCW-1:0]   nf;
  logic [PCW-1:0]   h;
  logic [3:0]       ppc;
  logic             kind;
  logic [1:0]       pclass;
  logic [3:0]       winner, runner;
  logic [2:0]       ucase;
  logic [15:0]      weight;

  assign in_op = op_e'(s_axis_tuser);

  lvq_ctrl #(
    .MAX_P(MAX_PROTOTYPES), .MAX_F(MAX_FEATURES),
    .PW(PW), .FW(FW), .PCW(PCW), .FCW(FCW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (in_op),
    .in_last_i  (s_axis_tlast),
    .sts_i      (sts),
    .nf_i       (nf),
    .h_i        (h),
    .ppc_i      (ppc),
    .cmd_o      (cmd),
    .proto_o    (proto),
    .feat_o     (feat),
    .cls_o      (cls)
  );

  lvq_datapath #(
    .MAX_P(MAX_PROTOTYPES), .MAX_F(MAX_FEATURES), .MAX_C(MAX_CLASSES),
    .PW(PW), .FW(FW), .PCW(PCW), .FCW(FCW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_op_i         (in_op),
    .in_value_i      (s_axis_tdata[15:0]),
    .in_last_i       (s_axis_tlast),
    .in_true_class_i (s_axis_tdata[17:16]),
    .in_proto_i      (s_axis_tdata[21:18]),
    .in_feat_i       (s_axis_tdata[25:22]),
    .cmd_i           (cmd),
    .proto_i         (proto),
    .feat_i          (feat),
    .cls_i           (cls),
    .sts_o           (sts),
    .nf_o            (nf),
    .h_o             (h),
    .ppc_o           (ppc),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_kind_o      (kind),
    .out_class_o     (pclass),
    .out_winner_o    (winner),
    .out_runner_o    (runner),
    .out_case_o      (ucase),
    .out_weight_o    (weight)
  );

  assign m_axis_tdata = {3'b000, weight, ucase, runner, winner, pclass};
  assign m_axis_tuser = kind;

endmodule
`default_nettype wire

// ===== hdl/lvq_chk.sv =====
`default_nettype none
module lvq_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[12:0] == 13'd0)
    else $error("weight read beat carries class fields");

  a_class_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[28:13] == 16'd0)
    else $error("class beat carries weight data");

  a_case_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:10] != 3'd5 && m_axis_tdata[12:10] != 3'd6 &&
      m_axis_tdata[12:10] != 3'd7 && m_axis_tdata[31:29] == 3'd0)
    else $error("bad update case or pad bits");

endmodule

bind lvq_classify_and_train_core lvq_chk u_lvq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import lvq_pkg::*;

  typedef struct {
    bit        kind;
    bit [1:0]  cls;
    bit [3:0]  win;
    bit [3:0]  run;
    bit [2:0]  ucase;
    bit [15:0] wval;
  } lvq_result_t;

  class lvq_mirror;
    int              weights[256];
    int              samples[16];
    longint unsigned dist_sq[16];
    bit [31:0]       rate;
    int unsigned     elem_cnt;
    bit [4:0]        r_feat;
    bit [2:0]        r_cls;
    bit [3:0]        r_ppc;
    bit [31:0]       r_init;
    bit [31:0]       r_decay;
    bit [15:0]       r_window;
    lvq_result_t     pending_results[$];
    int              errors;
    int              n_class;
    int              n_train;
    int              n_read;
    int              case_seen[5];

    function void reset_state();
      r_feat = FEATURES_RST;
      r_cls = CLASSES_RST;
      r_ppc = PPC_RST;
      r_init = RATE_RST;
      r_decay = DECAY_RST;
      r_window = WINDOW_RST;
      rate = RATE_RST;
      elem_cnt = 0;
    endfunction

    function void set_reg(cfg_e idx, bit [31:0] v);
      case (idx)
        CFG_FEATURES:  r_feat = v[4:0];
        CFG_CLASSES:   r_cls = v[2:0];
        CFG_PPC:       r_ppc = v[3:0];
        CFG_INIT_RATE: begin
          r_init = v;
          rate = v;
        end
        CFG_DECAY:     r_decay = v;
        CFG_WINDOW:    r_window = v[15:0];
        default: ;
      endcase
    endfunction

    function int feat_count();
      if (r_feat == 0) return 1;
      if (r_feat > 16) return 16;
      return r_feat;
    endfunction

    function int per_class();
      return (r_ppc == 0) ? 1 : r_ppc;
    endfunction

    function int proto_count();
      int c;
      int h;
      c = (r_cls < 2) ? 2 : ((r_cls > 4) ? 4 : r_cls);
      h = c * per_class();
      return (h > 16) ? 16 : h;
    endfunction

    function void nudge(int p, bit [31:0] r, bit attract, int n);
      int     wv;
      int     d;
      longint mag;
      longint delta;
      longint nv;
      for (int j = 0; j < n; j++) begin
        wv = weights[p*16+j];
        d = samples[j] - wv;
        mag = (d < 0) ? -d : d;
        delta = longint'((longint'(r) * mag + 64'h8000_0000) >>> 32);
        if (d < 0) delta = -delta;
        nv = attract ? wv + delta : wv - delta;
        if (nv > 32767) nv = 32767;
        if (nv < -32768) nv = -32768;
        weights[p*16+j] = int'(nv);
      end
    endfunction

    function void take_beat(op_e op, bit [15:0] val, bit [1:0] tc, bit [3:0] pi, bit [3:0] fi,
                            bit last);
      lvq_result_t     r;
      int              x;
      int              n;
      int              h;
      int              p;
      int              w1;
      int              w2;
      int              w3;
      int              c1;
      int              c2;
      int              first;
      int              stop;
      bit              differ;
      bit              t1;
      bit              t2;
      bit              winok;
      bit [31:0]       r3;
      longint          d;
      longint unsigned acc;
      x = int'($signed(val));
      r = '{default: 0};
      if (op == OP_WRITE) begin
        weights[pi*16+fi] = x;
        return;
      end
      if (op == OP_READ) begin
        r.kind = KIND_WEIGHT;
        r.wval = 16'(weights[pi*16+fi]);
        pending_results.push_back(r);
        n_read++;
        return;
      end
      n = feat_count();
      if (elem_cnt < n) begin
        samples[elem_cnt] = x;
        elem_cnt++;
      end
      if (!last) return;
      elem_cnt = 0;
      h = proto_count();
      p = per_class();
      for (int i = 0; i < h; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) begin
          d = longint'(samples[j]) - weights[i*16+j];
          acc += longint'(d * d);
        end
        dist_sq[i] = acc;
      end
      w1 = 0;
      for (int i = 1; i < h; i++) if (dist_sq[i] < dist_sq[w1]) w1 = i;
      c1 = w1 / p;
      w2 = 0;
      r.ucase = UPD_NONE;
      if (op == OP_TRAIN) begin
        w2 = (w1 == 0) ? 1 : 0;
        for (int i = 0; i < h; i++) if (i != w1 && dist_sq[i] < dist_sq[w2]) w2 = i;
        c2 = w2 / p;
        differ = c1 != c2;
        t1 = c1 == tc;
        t2 = c2 == tc;
        winok = (dist_sq[w1] << 16) > longint'(r_window) * dist_sq[w2];
        if (differ && t1 && winok) begin
          r.ucase = UPD_ATTR_REP;
          nudge(w1, rate, 1, n);
          nudge(w2, rate, 0, n);
        end else if (differ && t2 && winok) begin
          r.ucase = UPD_REP_ATTR;
          nudge(w1, rate, 0, n);
          nudge(w2, rate, 1, n);
        end else if (!differ && t1 && winok) begin
          r3 = 32'((longint'(rate) * RATE_0P4 + 64'h8000) >> 16);
          r.ucase = UPD_BOTH;
          nudge(w1, r3, 1, n);
          nudge(w2, r3, 1, n);
        end else if (!t1 && !t2) begin
          first = tc * p;
          if (first < h) begin
            stop = (first + p > h) ? h : first + p;
            w3 = first;
            for (int i = first; i < stop; i++) if (dist_sq[i] < dist_sq[w3]) w3 = i;
            r.ucase = UPD_CLASS;
            nudge(w3, rate, 1, n);
          end
        end
        rate = 32'((longint'(rate) * longint'(r_decay)) >> 32);
        n_train++;
      end else begin
        n_class++;
      end
      case_seen[r.ucase]++;
      r.kind = KIND_CLASS;
      r.cls = 2'(c1);
      r.win = 4'(w1);
      r.run = 4'(w2);
      pending_results.push_back(r);
    endfunction

    function void check_result(bit kind, bit [31:0] d);
      lvq_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: kind %0d data %h", kind, d);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (kind != e.kind) begin
        $error("result_kind expected %0d got %0d", e.kind, kind);
        errors++;
      end
      if (d[1:0] != e.cls) begin
        $error("predicted_class expected %0d got %0d", e.cls, d[1:0]);
        errors++;
      end
      if (d[5:2] != e.win) begin
        $error("winner_index expected %0d got %0d", e.win, d[5:2]);
        errors++;
      end
      if (d[9:6] != e.run) begin
        $error("runner_up_index expected %0d got %0d", e.run, d[9:6]);
        errors++;
      end
      if (d[12:10] != e.ucase) begin
        $error("update_case expected %0d got %0d", e.ucase, d[12:10]);
        errors++;
      end
      if (d[28:13] != e.wval) begin
        $error("weight_value expected %0d got %0d", $signed(e.wval), $signed(d[28:13]));
        errors++;
      end
      if (d[31:29] != 0) begin
        $error("tdata pad expected 0 got %0d", d[31:29]);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  lvq_mirror mirror;
  int        beats_sent;
  int        beats_seen;
  int        cycles;
  bit        long_hold_done;

  lvq_classify_and_train_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(op_e op, bit [15:0] val, bit [1:0] tc, bit [3:0] pi, bit [3:0] fi,
                           bit last);
    int gap;
    gap = (((beats_sent / 40) % 4) == 3) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tlast = last;
    s_axis_tdata = {6'd0, fi, pi, tc, val};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.take_beat(op, val, tc, pi, fi, last);
    beats_sent++;
  endtask

  task automatic weight_op(op_e op, bit [15:0] val, bit [3:0] pi, bit [3:0] fi);
    send_beat(op, val, 2'($urandom), pi, fi, 1'($urandom));
  endtask

  function automatic bit [15:0] pick_value(bit narrow);
    if (narrow) return 16'($urandom_range(0, 1023) - 512);
    return 16'($urandom);
  endfunction

  task automatic send_vector(op_e op, int len, bit [1:0] tc, bit narrow);
    for (int e = 0; e < len; e++) begin
      if ($urandom_range(0, 11) == 0)
        weight_op($urandom_range(0, 1) ? OP_READ : OP_WRITE, pick_value(1'b1),
                  4'($urandom), 4'($urandom));
      send_beat(op, pick_value(narrow), tc, 4'($urandom), 4'($urandom), e == len - 1);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, bit [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mirror.set_reg(idx, v);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && beats_seen == 10) begin
        stall = 400;
        long_hold_done = 1'b1;
      end else if (((beats_seen / 50) % 4) == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      mirror.check_result(m_axis_tuser[0], m_axis_tdata);
      beats_seen++;
    end
  end

  initial begin
    bit [31:0] feat_set[5];
    bit [31:0] cls_set[5];
    bit [31:0] ppc_set[5];
    bit [31:0] rate_set[4];
    bit [31:0] decay_set[3];
    bit [31:0] win_set[4];
    int        nf;
    int        len;
    int        budget;
    op_e       vop;
    mirror = new();
    mirror.reset_state();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = OP_CLASSIFY;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_FEATURES;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 16; p++)
      for (int f = 0; f < 16; f++)
        weight_op(OP_WRITE, pick_value(1'b1), 4'(p), 4'(f));

    // extremes of the weight range
    weight_op(OP_WRITE, 16'h8000, 4'd0, 4'd0);
    weight_op(OP_WRITE, 16'h7fff, 4'd15, 4'd15);
    weight_op(OP_READ, 16'h0, 4'd0, 4'd0);
    weight_op(OP_READ, 16'hffff, 4'd15, 4'd15);
    send_beat(OP_CLASSIFY, 16'h7fff, 2'd0, 4'd0, 4'd0, 1'b0);
    send_beat(OP_CLASSIFY, 16'h8000, 2'd0, 4'd0, 4'd0, 1'b0);
    send_vector(OP_CLASSIFY, 14, 2'd0, 1'b1);
    send_vector(OP_TRAIN, 16, 2'd1, 1'b1);
    send_vector(OP_TRAIN, 16, 2'd3, 1'b0);
    settle();

    feat_set = '{1, 16, 0, 31, 4};
    cls_set = '{2, 4, 0, 7, 3};
    ppc_set = '{1, 8, 0, 15, 2};
    rate_set = '{0, 32'hffff_ffff, RATE_RST, 32'h2000_0000};
    decay_set = '{0, 32'hffff_ffff, DECAY_RST};
    win_set = '{0, 65535, WINDOW_RST, 30000};

    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 5) begin
        feat_set[4] = $urandom_range(2, 15);
        cls_set[4] = $urandom_range(2, 4);
        ppc_set[4] = $urandom_range(1, 8);
        rate_set[3] = $urandom;
        win_set[3] = $urandom_range(0, 65535);
      end
      write_reg(CFG_FEATURES, feat_set[ph % 5]);
      write_reg(CFG_CLASSES, cls_set[(ph + 2) % 5]);
      write_reg(CFG_PPC, ppc_set[(ph * 3) % 5]);
      write_reg(CFG_INIT_RATE, rate_set[ph % 4]);
      write_reg(CFG_DECAY, decay_set[ph % 3]);
      write_reg(CFG_WINDOW, win_set[(ph + 1) % 4]);
      nf = mirror.feat_count();
      budget = 14;
      while (budget > 0) begin
        case ($urandom_range(0, 5))
          0: len = $urandom_range(1, nf);
          1: len = nf + $urandom_range(1, 3);
          default: len = nf;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          weight_op(op_e'($urandom_range(2, 3)), pick_value(1'b0), 4'($urandom), 4'($urandom));
          budget--;
        end else begin
          vop = $urandom_range(0, 2) ? OP_TRAIN : OP_CLASSIFY;
          send_vector(vop, len, 2'($urandom), $urandom_range(0, 4) != 0);
          budget -= len;
        end
      end
      settle();
    end

    $display("checked %0d classify, %0d train and %0d weight read results over %0d beats",
             mirror.n_class, mirror.n_train, mirror.n_read, beats_sent);
    $display("update cases none/ar/ra/both/class: %0d %0d %0d %0d %0d", mirror.case_seen[0],
             mirror.case_seen[1], mirror.case_seen[2], mirror.case_seen[3], mirror.case_seen[4]);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
